>>> rtl/rycc_pkg.sv
// Shared types and constants of the RGB / YCbCr color converter.
`timescale 1ns / 1ps

package rycc_pkg;

  typedef enum logic {
    DIR_FWD = 1'b0,
    DIR_REV = 1'b1
  } dir_t;

  localparam int SUM_W       = 31;
  localparam int MAG_W       = 28;
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 48;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam int ACC_W       = 10;

  // Reciprocal of one million, exact for every magnitude below 2**MAG_W.
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(281474977);

  localparam logic signed [SUM_W-1:0] K_Y_R     = SUM_W'(299000);
  localparam logic signed [SUM_W-1:0] K_Y_G     = SUM_W'(587000);
  localparam logic signed [SUM_W-1:0] K_Y_B     = SUM_W'(114000);
  localparam logic signed [SUM_W-1:0] K_CB_R    = SUM_W'(168736);
  localparam logic signed [SUM_W-1:0] K_CB_G    = SUM_W'(331264);
  localparam logic signed [SUM_W-1:0] K_HALF_C  = SUM_W'(500000);
  localparam logic signed [SUM_W-1:0] K_CR_G    = SUM_W'(418688);
  localparam logic signed [SUM_W-1:0] K_CR_B    = SUM_W'(81312);
  localparam logic signed [SUM_W-1:0] K_R_CR    = SUM_W'(1402000);
  localparam logic signed [SUM_W-1:0] K_B_CB    = SUM_W'(1772000);
  localparam logic signed [SUM_W-1:0] K_G_CB    = SUM_W'(344136);
  localparam logic signed [SUM_W-1:0] K_G_CR    = SUM_W'(714136);
  localparam logic signed [SUM_W-1:0] CHROMA_OFS     = SUM_W'(128);
  localparam logic signed [SUM_W-1:0] CHROMA_OFS_SUM = SUM_W'(128000000);
  localparam logic signed [SUM_W-1:0] ROUND_HALF     = SUM_W'(500000);

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
  } pix_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [7:0]            base;
  } sums_t;

endpackage

>>> rtl/rycc_ifs.sv
// Channel interfaces of the RGB / YCbCr color converter.
`timescale 1ns / 1ps

interface rycc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] comp_first;
  logic [7:0] comp_second;
  logic [7:0] comp_third;
  modport source (output valid, comp_first, comp_second, comp_third, input ready);
  modport sink (input valid, comp_first, comp_second, comp_third, output ready);
endinterface

interface rycc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic [7:0] out_third;
  modport source (output valid, out_first, out_second, out_third, input ready);
  modport sink (input valid, out_first, out_second, out_third, output ready);
endinterface

interface rycc_cfg_if;
  logic valid;
  logic ready;
  logic direction;
  modport source (output valid, direction, input ready);
  modport sink (input valid, direction, output ready);
endinterface

>>> rtl/rycc_capture.sv
// Input register stage that holds one accepted pixel.
`timescale 1ns / 1ps

module rycc_capture
  import rycc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  pix_t in_pix,
  output logic out_valid,
  input  logic out_ready,
  output pix_t out_pix
);

  logic valid_r;
  pix_t pix_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_pix   = pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix_r <= in_pix;
    end
  end

endmodule

>>> rtl/rycc_weight.sv
// Weighted sum stage: signed sums in millionths, split into sign and rounded magnitude.
`timescale 1ns / 1ps

module rycc_weight
  import rycc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  dir_t  direction,
  input  logic  in_valid,
  output logic  in_ready,
  input  pix_t  in_pix,
  output logic  out_valid,
  input  logic  out_ready,
  output sums_t out_sums
);

  logic  valid_r;
  sums_t sums_r;
  sums_t sums_nxt;

  always_comb begin
    logic signed [SUM_W-1:0] av;
    logic signed [SUM_W-1:0] bv;
    logic signed [SUM_W-1:0] cv;
    logic signed [SUM_W-1:0] s [3];
    logic signed [SUM_W-1:0] absv;
    av = SUM_W'(in_pix.first);
    bv = SUM_W'(in_pix.second);
    cv = SUM_W'(in_pix.third);
    sums_nxt = '0;
    case (direction)
      DIR_FWD: begin
        s[0] = K_Y_R * av + K_Y_G * bv + K_Y_B * cv;
        s[1] = CHROMA_OFS_SUM - K_CB_R * av - K_CB_G * bv + K_HALF_C * cv;
        s[2] = CHROMA_OFS_SUM + K_HALF_C * av - K_CR_G * bv - K_CR_B * cv;
        sums_nxt.base = 8'd0;
      end
      DIR_REV: begin
        s[0] = K_R_CR * (cv - CHROMA_OFS);
        s[1] = -(K_G_CB * (bv - CHROMA_OFS)) - K_G_CR * (cv - CHROMA_OFS);
        s[2] = K_B_CB * (bv - CHROMA_OFS);
        sums_nxt.base = in_pix.first;
      end
      default: begin
        s[0] = '0;
        s[1] = '0;
        s[2] = '0;
        sums_nxt.base = 8'd0;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      sums_nxt.neg[i] = s[i][SUM_W-1];
      absv = s[i][SUM_W-1] ? -s[i] : s[i];
      absv = absv + ROUND_HALF;
      sums_nxt.mag[i] = absv[MAG_W-1:0];
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_sums  = sums_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sums_r <= sums_nxt;
    end
  end

endmodule

>>> rtl/rycc_round.sv
// Result stage: divide by 1e6, restore sign, add luma if DIR_REV, clamp to a byte.
`timescale 1ns / 1ps

module rycc_round
  import rycc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  sums_t in_sums,
  output logic  out_valid,
  input  logic  out_ready,
  output pix_t  out_pix
);

  logic       valid_r;
  logic [7:0] res_r   [3];
  logic [7:0] res_nxt [3];

  always_comb begin
    logic [PROD_W-1:0]       prod;
    logic [Q_W-1:0]          q;
    logic signed [ACC_W-1:0] basev;
    logic signed [ACC_W-1:0] qv;
    logic signed [ACC_W-1:0] val;
    basev = $signed(ACC_W'(in_sums.base));
    for (int i = 0; i < 3; i++) begin
      prod = PROD_W'(in_sums.mag[i]) * PROD_W'(RECIP);
      q    = prod[PROD_W-1:RECIP_SHIFT];
      qv   = $signed(ACC_W'(q));
      val  = in_sums.neg[i] ? basev - qv : basev + qv;
      if (val[ACC_W-1]) begin
        res_nxt[i] = 8'd0;
      end else if (val > $signed(ACC_W'(255))) begin
        res_nxt[i] = 8'd255;
      end else begin
        res_nxt[i] = val[7:0];
      end
    end
  end

  assign in_ready       = !valid_r || out_ready;
  assign out_valid      = valid_r;
  assign out_pix.first  = res_r[0];
  assign out_pix.second = res_r[1];
  assign out_pix.third  = res_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> rtl/rgb_ycbcr_color_converter_unit.sv
// Top level of the BT.601 full-range RGB / YCbCr pixel converter.
// Usage:
// The in_chan channel takes one 8-bit three-component pixel per transfer.
// The out_chan channel delivers exactly one converted pixel per input pixel,
// in order. The cfg_chan channel writes the direction bit: 0 converts RGB to
// YCbCr, 1 converts YCbCr to RGB. It is always ready and should only be
// written while no pixel is in flight.
// The datapath is three register stages: input capture, weighted sums, and
// divide, round and clamp. A pixel accepted on in_chan is registered in each
// stage in turn before it can leave on out_chan. Throughput is one pixel
// per cycle without a stall, set by the single pass through each stage.
// Synchronous reset clears all stage valid flags and sets the direction to
// RGB to YCbCr. When the receiver stalls, each stage holds its pixel and
// in_chan keeps accepting until all three stages are full.
`timescale 1ns / 1ps

module rgb_ycbcr_color_converter_unit
  import rycc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rycc_in_if.sink    in_chan,
  rycc_out_if.source out_chan,
  rycc_cfg_if.sink   cfg_chan
);

  dir_t  dir_r;
  pix_t  in_pix;
  pix_t  cap_pix;
  logic  cap_valid;
  logic  cap_ready;
  sums_t wgt_sums;
  logic  wgt_valid;
  logic  wgt_ready;
  pix_t  res_pix;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_FWD;
    end else if (cfg_chan.valid) begin
      dir_r <= dir_t'(cfg_chan.direction);
    end
  end

  assign in_pix.first  = in_chan.comp_first;
  assign in_pix.second = in_chan.comp_second;
  assign in_pix.third  = in_chan.comp_third;

  rycc_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_pix    (in_pix),
    .out_valid (cap_valid),
    .out_ready (cap_ready),
    .out_pix   (cap_pix)
  );

  rycc_weight u_weight (
    .clk       (clk),
    .rst_n     (rst_n),
    .direction (dir_r),
    .in_valid  (cap_valid),
    .in_ready  (cap_ready),
    .in_pix    (cap_pix),
    .out_valid (wgt_valid),
    .out_ready (wgt_ready),
    .out_sums  (wgt_sums)
  );

  rycc_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wgt_valid),
    .in_ready  (wgt_ready),
    .in_sums   (wgt_sums),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_pix   (res_pix)
  );

  assign out_chan.out_first  = res_pix.first;
  assign out_chan.out_second = res_pix.second;
  assign out_chan.out_third  = res_pix.third;

endmodule
